// ===== src/sorted_set_table_assert.svh =====
// assertion macros shared by the checker of the sorted set table
// no dependencies; take in with `include before use
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// same-cycle implication, held off during reset
`define SST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sst assertion failed");

// next-cycle implication, held off during reset
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sst assertion failed");

`endif

// ===== src/sst_pkg.sv =====
// types and codes shared by the sorted set table modules
// no dependencies
`timescale 1ns / 1ps

package sst_pkg;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  // status codes of a result beat
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_SHR,
    S_PLACE,
    S_SHL,
    S_FINISH
  } state_t;

  // one finished result, handed from the sequencer to the output register
  typedef struct packed {
    status_t            status;
    logic signed [31:0] value;
    logic        [4:0]  count;
    logic               empty;
  } sst_result_t;

endpackage

// ===== src/sorted_set_table.sv =====
// sorted set table: a table of distinct signed 32-bit values kept in ascending order.
// Input channel (in_valid/in_ready) carries one beat per operation: kind selects
// insert, pop largest, remove value or find value, and value is the operand.
// Output channel (out_valid/out_ready) carries one result beat per input beat:
// status, result_value, entry_count and is_empty after the operation.
// One operation at a time: in_ready is high only while the sequencer is idle.
// Steps from acceptance to the result beat: pop or remove on an empty table goes
// straight to the finish state, any other pop reads the top entry first, and find,
// remove and insert walk the entries below the match position, then move one entry
// per step to open or close a gap, and an inserted value is placed in a last step.
// A new beat is taken in the cycle after the result is handed over.
// The single read port of the entry store and the one shared compare see one entry
// per cycle, which sets the walk.
// The result waits in an output register; a new beat is taken while it waits,
// and if the receiver stalls longer the sequencer holds its finished result.
// Reset (rst, synchronous, active high) empties the table at once and drops any
// pending result; the entry store itself is not cleared.
// depends on sst_pkg, sst_mem, sst_ctrl
`timescale 1ns / 1ps

module sorted_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  kind,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [2:0]  status,
  output logic signed [31:0] result_value,
  output logic        [4:0]  entry_count,
  output logic               is_empty
);

  import sst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic               out_free, done;
  sst_result_t        result;
  logic               rd_en, we;
  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] rdata, wdata;

  assign out_free = !out_valid || out_ready;

  sst_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .out_free (out_free),
    .done     (done),
    .result   (result),
    .rd_en    (rd_en),
    .raddr    (raddr),
    .rdata    (rdata),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata)
  );

  sst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rd_en (rd_en),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // output register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register, payload
  always_ff @(posedge clk) begin
    if (done) begin
      status       <= result.status;
      result_value <= result.value;
      entry_count  <= result.count;
      is_empty     <= result.empty;
    end
  end

endmodule

// ===== src/sst_mem.sv =====
// entry store of the sorted set table: one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps

module sst_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic        [AW-1:0] raddr,
  output logic signed [31:0]   rdata,
  input  logic                 we,
  input  logic        [AW-1:0] waddr,
  input  logic signed [31:0]   wdata
);

  logic signed [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sst_ctrl.sv =====
// sequencer of the sorted set table: search walk, shift walks and the shared compare
// depends on sst_pkg; drives the ports of sst_mem
`timescale 1ns / 1ps

module sst_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic        [1:0]     kind,
  input  logic signed [31:0]    value,
  input  logic                  out_free,
  output logic                  done,
  output sst_pkg::sst_result_t  result,
  output logic                  rd_en,
  output logic        [AW-1:0]  raddr,
  input  logic signed [31:0]    rdata,
  output logic                  we,
  output logic        [AW-1:0]  waddr,
  output logic signed [31:0]    wdata
);

  import sst_pkg::*;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_t             state, state_next;
  op_t                op;
  logic signed [31:0] val;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      j, j_next;
  status_t            res_status, res_status_next;
  logic signed [31:0] res_value, res_value_next;

  // index arithmetic, one bit wider where a sum may reach the capacity
  logic [CW:0]        idx_inc, j_inc, j_inc2;
  logic [CW-1:0]      j_dec, j_dec2, cnt_dec;
  logic [CW+4:0]      cnt_wide;
  logic               hit_end, less, found;

  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign j_inc    = {1'b0, j} + 1'b1;
  assign j_inc2   = {1'b0, j} + 2'd2;
  assign j_dec    = j - 1'b1;
  assign j_dec2   = j - 2'd2;
  assign cnt_dec  = count - 1'b1;
  assign cnt_wide = {5'd0, count};

  // shared compare of the entry just read against the beat's value
  assign hit_end = (idx >= count);
  assign less    = !hit_end && (rdata < val);
  assign found   = !hit_end && (rdata == val);

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= op_t'(kind);
      val <= value;
    end
    idx        <= idx_next;
    j          <= j_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  // next state, memory requests and result
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    j_next          = j;
    res_status_next = res_status;
    res_value_next  = res_value;
    in_ready        = 1'b0;
    done            = 1'b0;
    rd_en           = 1'b0;
    raddr           = idx[AW-1:0];
    we              = 1'b0;
    waddr           = j[AW-1:0];
    wdata           = rdata;
    result.status   = res_status;
    result.value    = res_value;
    result.count    = cnt_wide[4:0];
    result.empty    = (count == '0);

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_status_next = ST_OK;
          res_value_next  = '0;
          idx_next        = '0;
          priority if (op_t'(kind) == OP_POP || op_t'(kind) == OP_REMOVE) begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_FINISH;
            end else if (op_t'(kind) == OP_POP) begin
              rd_en      = 1'b1;
              raddr      = cnt_dec[AW-1:0];
              state_next = S_POP;
            end else begin
              rd_en      = 1'b1;
              raddr      = '0;
              state_next = S_SEARCH;
            end
          end else begin
            // insert and find walk even an empty table
            rd_en      = (count != '0);
            raddr      = '0;
            state_next = S_SEARCH;
          end
        end
      end

      S_POP: begin
        res_value_next = rdata;
        count_next     = cnt_dec;
        state_next     = S_FINISH;
      end

      // walk up to the first entry not less than the value
      S_SEARCH: begin
        if (less) begin
          idx_next = idx_inc[CW-1:0];
          if (idx_inc < {1'b0, count}) begin
            rd_en = 1'b1;
            raddr = idx_inc[AW-1:0];
          end
        end else begin
          unique case (op)
            OP_FIND: begin
              if (found) begin
                res_value_next = val;
              end else begin
                res_status_next = ST_MISSING;
              end
              state_next = S_FINISH;
            end
            OP_INSERT: begin
              priority if (found) begin
                res_status_next = ST_DUP;
                state_next      = S_FINISH;
              end else if (count == CAP_CNT) begin
                res_status_next = ST_FULL;
                state_next      = S_FINISH;
              end else if (count > idx) begin
                j_next     = count;
                rd_en      = 1'b1;
                raddr      = cnt_dec[AW-1:0];
                state_next = S_SHR;
              end else begin
                state_next = S_PLACE;
              end
            end
            OP_REMOVE: begin
              priority if (!found) begin
                res_status_next = ST_MISSING;
                state_next      = S_FINISH;
              end else if (idx_inc < {1'b0, count}) begin
                j_next     = idx;
                rd_en      = 1'b1;
                raddr      = idx_inc[AW-1:0];
                state_next = S_SHL;
              end else begin
                count_next = cnt_dec;
                state_next = S_FINISH;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      // open a gap: move entries up one place, top first
      S_SHR: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = rdata;
        if ({1'b0, j} > idx_inc) begin
          rd_en      = 1'b1;
          raddr      = j_dec2[AW-1:0];
          j_next     = j_dec;
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = val;
        count_next = count + 1'b1;
        state_next = S_FINISH;
      end

      // close the gap: move entries down one place, bottom first
      S_SHL: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = rdata;
        if (j_inc2 < {1'b0, count}) begin
          rd_en  = 1'b1;
          raddr  = j_inc2[AW-1:0];
          j_next = j_inc[CW-1:0];
        end else begin
          count_next = cnt_dec;
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sst_checker.sv =====
// port-level checks of the sorted set table, bound onto the top level
// depends on sst_pkg and sorted_set_table_assert.svh
`timescale 1ns / 1ps

`include "sorted_set_table_assert.svh"

module sst_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [2:0]  status,
  input logic signed [31:0] result_value,
  input logic        [4:0]  entry_count,
  input logic               is_empty
);

  import sst_pkg::*;

  logic [40:0] out_beat;
  logic        no_entries;

  // whole result payload, and the empty-table view of it
  assign out_beat   = {status, result_value, entry_count, is_empty};
  assign no_entries = is_empty && (entry_count == 5'd0);

  // a stalled result beat holds
  `SST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_beat))

  // one operation at a time: busy right after a beat is taken
  `SST_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // a value is returned only with a good status
  `SST_ASSERT_NOW(a_value_zero_on_fail, clk, rst, out_valid && status != ST_OK, result_value == '0)

  // an empty-table refusal leaves the table empty
  `SST_ASSERT_NOW(a_empty_flag, clk, rst, out_valid && (status == ST_EMPTY), no_entries)

endmodule

bind sorted_set_table sst_checker u_sst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .result_value (result_value),
  .entry_count  (entry_count),
  .is_empty     (is_empty)
);

// ===== tb/sorted_set_table_tb.sv =====
// self-checking bench for the sorted set table: directed table, then random episodes
// depends on sst_pkg, sorted_set_table; results match typed rows or a local model
`timescale 1ns / 1ps

module sorted_set_table_tb;
  import sst_pkg::*;

  localparam int CAP = 16;
  localparam int RANDOM_BEATS = 1800;
  localparam int EPISODE_LEN = 60;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 2 * CAP + 10;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  // one directed row; reps > 1 repeats the beat with value stepping by stride
  typedef struct {
    op_t                k;
    logic signed [31:0] v;
    int                 reps;
    int                 stride;
    bit                 typed;
    sst_result_t        want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [1:0]  kind = OP_FIND;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [2:0]  status;
  logic signed [31:0] result_value;
  logic        [4:0]  entry_count;
  logic               is_empty;

  // local copy of the table contents
  logic signed [31:0] held_vals [CAP];
  int                 held_count = 0;

  sst_result_t        pending_results [$];
  plan_row_t          plan [$];
  logic signed [31:0] corner_vals [6];

  bit sender_steady = 1'b0;
  int beats_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int fills_to_cap = 0;
  int drains_to_zero = 0;
  int status_hits [5];

  sorted_set_table #(
    .CAPACITY(CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .result_value(result_value),
    .entry_count(entry_count),
    .is_empty(is_empty)
  );

  always #5 clk = ~clk;

  // run limit, well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // applies one operation to the local table and returns the result it gives
  function automatic sst_result_t predict_table_op(input op_t k, input logic signed [31:0] v);
    sst_result_t r;
    int pos;
    int i;
    bit hit;
    r.status = ST_OK;
    r.value = '0;
    pos = 0;
    while (pos < held_count && held_vals[pos] < v) pos++;
    hit = (pos < held_count) && (held_vals[pos] == v);
    case (k)
      OP_INSERT: begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (held_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (i = held_count; i > pos; i--) held_vals[i] = held_vals[i - 1];
          held_vals[pos] = v;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held_count--;
          r.value = held_vals[held_count];
        end
      end
      OP_REMOVE: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (!hit) begin
          r.status = ST_MISSING;
        end else begin
          for (i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i + 1];
          held_count--;
        end
      end
      default: begin
        if (hit) r.value = v;
        else r.status = ST_MISSING;
      end
    endcase
    r.count = 5'(held_count);
    r.empty = (held_count == 0);
    return r;
  endfunction

  // offers a beat after a random gap unless steady, then books its expected result
  task automatic drive_beat(input op_t k, input logic signed [31:0] v, input bit typed,
                            input sst_result_t want);
    int gap;
    int count_before;
    sst_result_t predicted;
    gap = sender_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    count_before = held_count;
    predicted = predict_table_op(k, v);
    if (held_count == CAP && count_before < CAP) fills_to_cap++;
    if (held_count == 0 && count_before > 0) drains_to_zero++;
    pending_results.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  task automatic plan_row(input op_t k, input logic signed [31:0] v, input int reps,
                          input int stride, input bit typed, input sst_result_t want);
    plan_row_t row;
    row.k = k;
    row.v = v;
    row.reps = reps;
    row.stride = stride;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // operand mix: stored entries, a narrow band for collisions, wide values, corners
  function automatic logic signed [31:0] pick_value();
    int roll;
    int narrow;
    roll = $urandom_range(0, 99);
    narrow = $urandom_range(0, 40);
    if (roll < 25 && held_count > 0) return held_vals[$urandom_range(0, held_count - 1)];
    if (roll < 70) return narrow - 20;
    if (roll < 88) return $urandom;
    return corner_vals[$urandom_range(0, 5)];
  endfunction

  function automatic op_t pick_op(input mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 65) return OP_INSERT;
        if (roll < 75) return OP_POP;
        if (roll < 85) return OP_REMOVE;
        return OP_FIND;
      end
      MIX_DRAIN: begin
        if (roll < 20) return OP_INSERT;
        if (roll < 55) return OP_POP;
        if (roll < 80) return OP_REMOVE;
        return OP_FIND;
      end
      default: begin
        if (roll < 25) return OP_INSERT;
        if (roll < 50) return OP_POP;
        if (roll < 75) return OP_REMOVE;
        return OP_FIND;
      end
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    logic signed [31:0] v;
    mix_t mix;
    corner_vals[0] = 32'sh8000_0000;
    corner_vals[1] = 32'sh8000_0001;
    corner_vals[2] = 32'sh7fff_ffff;
    corner_vals[3] = 32'sh7fff_fffe;
    corner_vals[4] = -32'sd1;
    corner_vals[5] = 32'sd0;

    // empty table, extremes, full table, head and tail removal
    plan_row(OP_POP, 32'sd0, 1, 0, 1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1});
    plan_row(OP_REMOVE, 32'sd5, 1, 0, 1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1});
    plan_row(OP_FIND, 32'sd0, 1, 0, 1, '{ST_MISSING, 32'sd0, 5'd0, 1'b1});
    plan_row(OP_INSERT, 32'sh8000_0000, 1, 0, 1, '{ST_OK, 32'sd0, 5'd1, 1'b0});
    plan_row(OP_INSERT, 32'sh7fff_ffff, 1, 0, 1, '{ST_OK, 32'sd0, 5'd2, 1'b0});
    plan_row(OP_INSERT, 32'sd70, CAP - 2, -5, 0, '0);
    plan_row(OP_INSERT, 32'sh8000_0000, 1, 0, 1, '{ST_DUP, 32'sd0, 5'd16, 1'b0});
    plan_row(OP_INSERT, 32'sd0, 1, 0, 1, '{ST_FULL, 32'sd0, 5'd16, 1'b0});
    plan_row(OP_FIND, 32'sh7fff_ffff, 1, 0, 1, '{ST_OK, 32'sh7fff_ffff, 5'd16, 1'b0});
    plan_row(OP_FIND, -32'sd1, 1, 0, 1, '{ST_MISSING, 32'sd0, 5'd16, 1'b0});
    plan_row(OP_REMOVE, 32'sh8000_0000, 1, 0, 1, '{ST_OK, 32'sd0, 5'd15, 1'b0});
    plan_row(OP_REMOVE, 32'sh7fff_ffff, 1, 0, 1, '{ST_OK, 32'sd0, 5'd14, 1'b0});
    plan_row(OP_REMOVE, 32'sd7, 1, 0, 1, '{ST_MISSING, 32'sd0, 5'd14, 1'b0});
    plan_row(OP_POP, 32'sd0, 1, 0, 1, '{ST_OK, 32'sd70, 5'd13, 1'b0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      for (int n = 0; n < plan[r].reps; n++) begin
        drive_beat(plan[r].k, plan[r].v + n * plan[r].stride, plan[r].typed, plan[r].want);
      end
    end

    // random episodes, each leaning towards filling, draining or neither
    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % EPISODE_LEN == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        if (held_count < 3) mix = MIX_FILL;
        if (held_count > CAP - 3) mix = MIX_DRAIN;
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      v = pick_value();
      drive_beat(pick_op(mix), v, 0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d beats offered, %0d results checked; table filled %0d times, emptied %0d times",
             beats_sent, results_seen, fills_to_cap, drains_to_zero);
    $display("status counts: ok %0d, dup %0d, full %0d, missing %0d, empty %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls, two long hold-offs, field-by-field compare
  initial begin
    int hold;
    sst_result_t want;
    foreach (status_hits[s]) status_hits[s] = 0;
    repeat (2) @(posedge clk);
    forever begin
      if (results_seen == 500 || results_seen == 1400) begin
        hold = LONG_HOLD;
      end else if ((results_seen / 100) % 5 == 4) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 10);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (status < 5) status_hits[status]++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected (status %0d)", status));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (result_value !== want.value)
          flag_mismatch($sformatf("result_value %0d, expected %0d", result_value, want.value));
        if (entry_count !== want.count)
          flag_mismatch($sformatf("entry_count %0d, expected %0d", entry_count, want.count));
        if (is_empty !== want.empty)
          flag_mismatch($sformatf("is_empty %0b, expected %0b", is_empty, want.empty));
      end
    end
  end

endmodule

// ===== sorted_set_table.f =====
+incdir+src
src/sst_pkg.sv
src/sst_mem.sv
src/sst_ctrl.sv
src/sorted_set_table.sv
src/sst_checker.sv
tb/sorted_set_table_tb.sv
